/* rtl/core/polygon_moment_of_inertia_unit_macros.svh */
// Assertion macros shared by the checker of the polygon inertia unit.
`ifndef POLYGON_MOMENT_OF_INERTIA_UNIT_MACROS_SVH
`define POLYGON_MOMENT_OF_INERTIA_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PMI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define PMI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/pmi_pkg.sv */
// Package of constants and helpers for the polygon inertia unit.
package pmi_pkg;

   localparam int DEFAULT_MAX_VERTICES = 1024;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_BODY_MASS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REF_POINT_X = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REF_POINT_Y = 2'd2;

   localparam logic [31:0] BODY_MASS_RESET = 32'h0001_0000;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FEW       = 2'd1;
   localparam logic [1:0] ST_ZERO_AREA = 2'd2;
   localparam logic [1:0] ST_SAT       = 2'd3;

   // Coordinate relative to the reference point, clamped to signed 32 bits.
   function automatic logic signed [31:0] rel_coord(logic [31:0] v, logic [31:0] r);
      logic signed [32:0] d;
      d = $signed({v[31], v}) - $signed({r[31], r});
      if (d[32] != d[31]) begin
         return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return d[31:0];
   endfunction

endpackage

/* rtl/core/polygon_moment_of_inertia_unit.sv */
// Polygon moment of inertia: shared multiplier, bit-serial divider and constant divider under a sequencer.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | vertex_x, vertex_y, last_vertex
//   rsp     | out       | rsp_valid/rsp_ready  | inertia_out, inv_inertia_out, area_out, status
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// A first vertex is only stored; a later vertex takes 16 multiplies, an 8-step divide by 6
// and an accumulate. A last vertex also runs the closing edge, then reports a degenerate
// polygon, or else runs 4 divides of 128 steps and 2 divides by 3 of 8 (no inverse divide at zero inertia).
// Reset is synchronous and clears the polygon and loads the register defaults.
// The result waits in an output register; the next polygon's result stalls on rsp_ready.
module polygon_moment_of_inertia_unit
   import pmi_pkg::*;
#(
   parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_vertex_x,
   input  logic signed [31:0]     req_vertex_y,
   input  logic                   req_last_vertex,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [63:0]            rsp_inertia_out,
   output logic [63:0]            rsp_inv_inertia_out,
   output logic [63:0]            rsp_area_out,
   output logic [1:0]             rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam logic [63:0] MAX64 = 64'hffff_ffff_ffff_ffff;
   // ceil(2^21 / d) for the constant divisors
   localparam logic [19:0] RECIP_3 = 20'd699051;
   localparam logic [19:0] RECIP_6 = 20'd349526;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0_0000_0000_0001,
      S_EMUL  = 13'b0_0000_0000_0010,
      S_DIV   = 13'b0_0000_0000_0100,
      S_ETERM = 13'b0_0000_0000_1000,
      S_FCHK  = 13'b0_0000_0001_0000,
      S_FN    = 13'b0_0000_0010_0000,
      S_FSC   = 13'b0_0000_0100_0000,
      S_FC1   = 13'b0_0000_1000_0000,
      S_FC2   = 13'b0_0001_0000_0000,
      S_FSQ   = 13'b0_0010_0000_0000,
      S_FINV  = 13'b0_0100_0000_0000,
      S_DONE  = 13'b0_1000_0000_0000,
      S_CDIV  = 13'b1_0000_0000_0000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [3:0]   step_ff, step_in;
   logic [6:0]   div_cnt_ff, div_cnt_in;
   logic [63:0]  rem_ff, rem_in, div_d_ff, div_d_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  p1_ff, p1_in, s_ff, s_in, area_tri_ff, area_tri_in, sq_ff, sq_in;
   logic signed [31:0] rax_ff, rax_in, ray_ff, ray_in, rbx_ff, rbx_in, rby_ff, rby_in;
   logic [31:0]  first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [31:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [63:0]  area_sum_ff, area_sum_in, inertia_sum_ff, inertia_sum_in;
   logic signed [63:0] cx_sum_ff, cx_sum_in, cy_sum_ff, cy_sum_in;
   logic         last_ff, last_in, close_ff, close_in, ysel_ff, ysel_in;
   logic [63:0]  scaled_ff, scaled_in;
   logic [31:0]  cxm_ff, cxm_in, cym_ff, cym_in;
   logic [63:0]  res_inertia_ff, res_inertia_in, res_inv_ff, res_inv_in;
   logic [1:0]   res_status_ff, res_status_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  rsp_inertia_ff, rsp_inertia_in, rsp_inv_ff, rsp_inv_in;
   logic [63:0]  rsp_area_ff, rsp_area_in;
   logic [1:0]   rsp_status_ff, rsp_status_in;
   logic [31:0]  mass_ff, mass_in, refx_ff, refx_in, refy_ff, refy_in;

   // Shared multiplier
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic [63:0]  prod64;
   logic [127:0] prod_ext;

   logic signed [32:0] sum_x, sum_y;
   logic [32:0]  mag_x, mag_y;

   // Divider datapath
   logic [64:0]  div_sh;
   logic         div_ge;
   logic [64:0]  div_diff;

   // Constant divider, one 16-bit digit per cycle
   logic [18:0]  cdiv_v;
   logic [19:0]  cdiv_m;
   logic [38:0]  cdiv_p;
   logic [15:0]  cdiv_q;
   logic [18:0]  cdiv_qd;
   logic [18:0]  cdiv_rf;

   function automatic logic signed [33:0] sx(logic [31:0] v);
      return $signed({{2{v[31]}}, v});
   endfunction

   function automatic logic signed [33:0] zx(logic [31:0] v);
      return $signed({2'b00, v});
   endfunction

   function automatic logic [63:0] mag64(logic signed [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   function automatic logic [63:0] sat64(logic [127:0] v);
      return (v[127:64] != 64'd0) ? MAX64 : v[63:0];
   endfunction

   function automatic logic [63:0] sat_add_u(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? MAX64 : s[63:0];
   endfunction

   // Finish a center term from the product in acc and add it to a signed sum.
   function automatic logic signed [63:0] center_add(logic signed [63:0] sum,
                                                     logic [127:0] p, logic neg);
      logic [63:0] m;
      logic [63:0] t;
      logic [64:0] s;
      m = (p[127:79] != 49'd0) ? 64'h7fff_ffff_ffff_ffff : {1'b0, p[78:16]};
      t = neg ? (~m + 64'd1) : m;
      s = {sum[63], sum} + {t[63], t};
      if (s[64] != s[63]) begin
         return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
      end
      return s[63:0];
   endfunction

   assign sum_x = $signed({rax_ff[31], rax_ff}) + $signed({rbx_ff[31], rbx_ff});
   assign sum_y = $signed({ray_ff[31], ray_ff}) + $signed({rby_ff[31], rby_ff});
   assign mag_x = sum_x[32] ? (~sum_x + 33'd1) : sum_x;
   assign mag_y = sum_y[32] ? (~sum_y + 33'd1) : sum_y;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_EMUL: begin
            case (step_ff)
               4'd0:  begin mul_a = sx(rax_ff); mul_b = sx(rby_ff); end
               4'd1:  begin mul_a = sx(ray_ff); mul_b = sx(rbx_ff); end
               4'd2:  begin mul_a = $signed({1'b0, mag_x}); mul_b = zx(area_tri_ff[31:0]); end
               4'd3:  begin mul_a = $signed({1'b0, mag_x}); mul_b = zx(area_tri_ff[63:32]); end
               4'd4:  begin mul_a = $signed({1'b0, mag_y}); mul_b = zx(area_tri_ff[31:0]); end
               4'd5:  begin mul_a = $signed({1'b0, mag_y}); mul_b = zx(area_tri_ff[63:32]); end
               4'd6:  begin mul_a = sx(rax_ff); mul_b = sx(rax_ff); end
               4'd7:  begin mul_a = sx(rbx_ff); mul_b = sx(rbx_ff); end
               4'd8:  begin mul_a = sx(ray_ff); mul_b = sx(ray_ff); end
               4'd9:  begin mul_a = sx(rby_ff); mul_b = sx(rby_ff); end
               4'd10: begin mul_a = sx(rax_ff); mul_b = sx(rbx_ff); end
               4'd11: begin mul_a = sx(ray_ff); mul_b = sx(rby_ff); end
               4'd12: begin mul_a = zx(area_tri_ff[31:0]);  mul_b = zx(s_ff[31:0]); end
               4'd13: begin mul_a = zx(area_tri_ff[31:0]);  mul_b = zx(s_ff[63:32]); end
               4'd14: begin mul_a = zx(area_tri_ff[63:32]); mul_b = zx(s_ff[31:0]); end
               default: begin mul_a = zx(area_tri_ff[63:32]); mul_b = zx(s_ff[63:32]); end
            endcase
         end
         S_FN: begin
            mul_a = zx(mass_ff);
            mul_b = (step_ff == 4'd0) ? zx(inertia_sum_ff[31:0]) : zx(inertia_sum_ff[63:32]);
         end
         S_FSQ: begin
            case (step_ff)
               4'd0:          begin mul_a = zx(cxm_ff); mul_b = zx(cxm_ff); end
               4'd3:          begin mul_a = zx(cym_ff); mul_b = zx(cym_ff); end
               4'd1, 4'd4:    begin mul_a = zx(mass_ff); mul_b = zx(sq_ff[31:0]); end
               4'd2, 4'd5:    begin mul_a = zx(mass_ff); mul_b = zx(sq_ff[63:32]); end
               default:       begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign prod64   = mul_p[63:0];
   assign prod_ext = {64'd0, prod64};

   assign div_sh   = {rem_ff, acc_ff[127]};
   assign div_ge   = div_sh >= {1'b0, div_d_ff};
   assign div_diff = div_sh - {1'b0, div_d_ff};

   // Digit quotient (v * ceil(2^21/d)) >> 21 is exact for v < d * 2^16.
   assign cdiv_v  = {rem_ff[2:0], acc_ff[127:112]};
   assign cdiv_m  = (div_d_ff[2:0] == 3'd6) ? RECIP_6 : RECIP_3;
   assign cdiv_p  = {20'd0, cdiv_v} * {19'd0, cdiv_m};
   assign cdiv_q  = cdiv_p[36:21];
   assign cdiv_qd = {3'd0, cdiv_q} * {16'd0, div_d_ff[2:0]};
   assign cdiv_rf = cdiv_v - cdiv_qd;

   always_comb begin
      logic        div_go;
      logic        div_const;
      logic [63:0] div_d_nxt;
      state_type   ret_nxt;
      logic signed [63:0] dcr;
      logic [63:0] cr;
      logic [63:0] atri;
      logic [63:0] term;
      logic [63:0] c64;
      logic [31:0] cap;
      logic [63:0] corr;
      logic [63:0] inert;

      div_go    = 1'b0;
      div_const = 1'b0;
      div_d_nxt = div_d_ff;
      ret_nxt   = ret_ff;
      dcr       = '0;
      cr        = '0;
      atri      = '0;
      term      = '0;
      c64       = '0;
      cap       = '0;
      corr      = '0;
      inert     = '0;

      state_in       = state_ff;
      ret_in         = ret_ff;
      step_in        = step_ff;
      div_cnt_in     = div_cnt_ff;
      rem_in         = rem_ff;
      div_d_in       = div_d_ff;
      acc_in         = acc_ff;
      p1_in          = p1_ff;
      s_in           = s_ff;
      area_tri_in    = area_tri_ff;
      sq_in          = sq_ff;
      rax_in         = rax_ff;
      ray_in         = ray_ff;
      rbx_in         = rbx_ff;
      rby_in         = rby_ff;
      first_x_in     = first_x_ff;
      first_y_in     = first_y_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      count_in       = count_ff;
      area_sum_in    = area_sum_ff;
      inertia_sum_in = inertia_sum_ff;
      cx_sum_in      = cx_sum_ff;
      cy_sum_in      = cy_sum_ff;
      last_in        = last_ff;
      close_in       = close_ff;
      ysel_in        = ysel_ff;
      scaled_in      = scaled_ff;
      cxm_in         = cxm_ff;
      cym_in         = cym_ff;
      res_inertia_in = res_inertia_ff;
      res_inv_in     = res_inv_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_inertia_in = rsp_inertia_ff;
      rsp_inv_in     = rsp_inv_ff;
      rsp_area_in    = rsp_area_ff;
      rsp_status_in  = rsp_status_ff;
      mass_in        = mass_ff;
      refx_in        = refx_ff;
      refy_in        = refy_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_BODY_MASS:   mass_in = csr_wdata;
            REG_REF_POINT_X: refx_in = csr_wdata;
            REG_REF_POINT_Y: refy_in = csr_wdata;
            default:         mass_in = mass_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               prev_x_in = req_vertex_x;
               prev_y_in = req_vertex_y;
               last_in   = req_last_vertex;
               if (count_ff < CNT_W'(MAX_VERTICES)) begin
                  count_in = count_ff + CNT_W'(1);
               end
               step_in = 4'd0;
               if (count_ff == '0) begin
                  first_x_in = req_vertex_x;
                  first_y_in = req_vertex_y;
                  // A lone last vertex closes onto itself.
                  if (req_last_vertex) begin
                     rax_in   = rel_coord(req_vertex_x, refx_ff);
                     ray_in   = rel_coord(req_vertex_y, refy_ff);
                     rbx_in   = rel_coord(req_vertex_x, refx_ff);
                     rby_in   = rel_coord(req_vertex_y, refy_ff);
                     close_in = 1'b0;
                     state_in = S_EMUL;
                  end
               end else begin
                  rax_in   = rel_coord(prev_x_ff, refx_ff);
                  ray_in   = rel_coord(prev_y_ff, refy_ff);
                  rbx_in   = rel_coord(req_vertex_x, refx_ff);
                  rby_in   = rel_coord(req_vertex_y, refy_ff);
                  close_in = req_last_vertex;
                  state_in = S_EMUL;
               end
            end
         end

         S_EMUL: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: p1_in = prod64;
               4'd1: begin
                  dcr         = $signed(p1_ff) - $signed(prod64);
                  cr          = ($signed(p1_ff) >= $signed(prod64)) ? dcr : (~dcr + 64'd1);
                  atri        = {1'b0, cr[63:1]};
                  area_tri_in = atri;
                  area_sum_in = sat_add_u(area_sum_ff, atri);
               end
               4'd2: acc_in = prod_ext;
               4'd3: acc_in = acc_ff + (prod_ext << 32);
               4'd4: begin
                  cx_sum_in = center_add(cx_sum_ff, acc_ff, sum_x[32]);
                  acc_in    = prod_ext;
               end
               4'd5: acc_in = acc_ff + (prod_ext << 32);
               4'd6: begin
                  cy_sum_in = center_add(cy_sum_ff, acc_ff, sum_y[32]);
                  s_in      = prod64;
               end
               4'd7, 4'd8, 4'd9, 4'd10, 4'd11: s_in = s_ff + prod64;
               4'd12: acc_in = prod_ext;
               4'd13: acc_in = acc_ff + (prod_ext << 32);
               4'd14: acc_in = acc_ff + (prod_ext << 32);
               default: begin
                  acc_in    = acc_ff + (prod_ext << 64);
                  div_go    = 1'b1;
                  div_const = 1'b1;
                  div_d_nxt = 64'd6;
                  ret_nxt   = S_ETERM;
               end
            endcase
         end

         S_DIV: begin
            // One restoring step: shift a numerator bit in, quotient bit out.
            div_cnt_in = div_cnt_ff + 7'd1;
            rem_in     = div_ge ? div_diff[63:0] : div_sh[63:0];
            acc_in     = {acc_ff[126:0], div_ge};
            if (div_cnt_ff == 7'd127) begin
               state_in = ret_ff;
            end
         end

         S_CDIV: begin
            // Long division by a small constant, one 16-bit digit per cycle.
            div_cnt_in = div_cnt_ff + 7'd1;
            rem_in     = {61'd0, cdiv_rf[2:0]};
            acc_in     = {acc_ff[111:0], cdiv_q};
            if (div_cnt_ff == 7'd7) begin
               state_in = ret_ff;
            end
         end

         S_ETERM: begin
            term = (acc_ff[127:96] != 32'd0) ? MAX64 : acc_ff[95:32];
            inertia_sum_in = sat_add_u(inertia_sum_ff, term);
            step_in = 4'd0;
            if (close_ff) begin
               close_in = 1'b0;
               rax_in   = rel_coord(prev_x_ff, refx_ff);
               ray_in   = rel_coord(prev_y_ff, refy_ff);
               rbx_in   = rel_coord(first_x_ff, refx_ff);
               rby_in   = rel_coord(first_y_ff, refy_ff);
               state_in = S_EMUL;
            end else if (last_ff) begin
               state_in = S_FCHK;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_FCHK: begin
            step_in = 4'd0;
            if (count_ff < CNT_W'(3)) begin
               res_inertia_in = '0;
               res_inv_in     = '0;
               res_status_in  = ST_FEW;
               state_in       = S_DONE;
            end else if (area_sum_ff == 64'd0) begin
               res_inertia_in = '0;
               res_inv_in     = '0;
               res_status_in  = ST_ZERO_AREA;
               state_in       = S_DONE;
            end else begin
               state_in = S_FN;
            end
         end

         S_FN: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd0) begin
               acc_in = prod_ext << 16;
            end else begin
               acc_in    = acc_ff + (prod_ext << 48);
               div_go    = 1'b1;
               div_d_nxt = area_sum_ff;
               ret_nxt   = S_FSC;
            end
         end

         S_FSC: begin
            scaled_in = sat64(acc_ff);
            acc_in    = {48'd0, mag64(cx_sum_ff), 16'd0};
            ysel_in   = 1'b0;
            div_go    = 1'b1;
            div_d_nxt = area_sum_ff;
            ret_nxt   = S_FC1;
         end

         S_FC1: begin
            acc_in    = {64'd0, sat64(acc_ff)};
            div_go    = 1'b1;
            div_const = 1'b1;
            div_d_nxt = 64'd3;
            ret_nxt   = S_FC2;
         end

         S_FC2: begin
            c64 = sat64(acc_ff);
            cap = (c64[63:32] != 32'd0) ? 32'hffff_ffff : c64[31:0];
            if (!ysel_ff) begin
               cxm_in    = cap;
               ysel_in   = 1'b1;
               acc_in    = {48'd0, mag64(cy_sum_ff), 16'd0};
               div_go    = 1'b1;
               div_d_nxt = area_sum_ff;
               ret_nxt   = S_FC1;
            end else begin
               cym_in   = cap;
               step_in  = 4'd0;
               state_in = S_FSQ;
            end
         end

         S_FSQ: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: begin
                  sq_in  = prod64;
                  acc_in = '0;
               end
               4'd3: sq_in = prod64;
               4'd1, 4'd4: acc_in = acc_ff + prod_ext;
               4'd2, 4'd5: acc_in = acc_ff + (prod_ext << 32);
               default: begin
                  corr  = (acc_ff[127:80] != 48'd0) ? MAX64 : acc_ff[79:16];
                  inert = (scaled_ff > corr) ? (scaled_ff - corr) : 64'd0;
                  res_inertia_in = inert;
                  res_status_in  = (inert == 64'd0 || scaled_ff == MAX64 ||
                                    inertia_sum_ff == MAX64) ? ST_SAT : ST_OK;
                  if (inert != 64'd0) begin
                     acc_in    = {64'd1, 64'd0};
                     div_go    = 1'b1;
                     div_d_nxt = inert;
                     ret_nxt   = S_FINV;
                  end else begin
                     res_inv_in = '0;
                     state_in   = S_DONE;
                  end
               end
            endcase
         end

         S_FINV: begin
            res_inv_in = sat64(acc_ff);
            state_in   = S_DONE;
         end

         S_DONE: begin
            // Hold until the output register is free, then drop the polygon.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_inertia_in = res_inertia_ff;
               rsp_inv_in     = res_inv_ff;
               rsp_area_in    = area_sum_ff;
               rsp_status_in  = res_status_ff;
               first_x_in     = '0;
               first_y_in     = '0;
               prev_x_in      = '0;
               prev_y_in      = '0;
               count_in       = '0;
               area_sum_in    = '0;
               inertia_sum_in = '0;
               cx_sum_in      = '0;
               cy_sum_in      = '0;
               last_in        = 1'b0;
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (div_go) begin
         rem_in     = '0;
         div_cnt_in = '0;
         div_d_in   = div_d_nxt;
         ret_in     = ret_nxt;
         state_in   = div_const ? S_CDIV : S_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         ret_ff         <= S_IDLE;
         first_x_ff     <= '0;
         first_y_ff     <= '0;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         count_ff       <= '0;
         area_sum_ff    <= '0;
         inertia_sum_ff <= '0;
         cx_sum_ff      <= '0;
         cy_sum_ff      <= '0;
         last_ff        <= 1'b0;
         close_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         mass_ff        <= BODY_MASS_RESET;
         refx_ff        <= '0;
         refy_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         ret_ff         <= ret_in;
         first_x_ff     <= first_x_in;
         first_y_ff     <= first_y_in;
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
         count_ff       <= count_in;
         area_sum_ff    <= area_sum_in;
         inertia_sum_ff <= inertia_sum_in;
         cx_sum_ff      <= cx_sum_in;
         cy_sum_ff      <= cy_sum_in;
         last_ff        <= last_in;
         close_ff       <= close_in;
         rsp_valid_ff   <= rsp_valid_in;
         mass_ff        <= mass_in;
         refx_ff        <= refx_in;
         refy_ff        <= refy_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      div_cnt_ff     <= div_cnt_in;
      rem_ff         <= rem_in;
      div_d_ff       <= div_d_in;
      acc_ff         <= acc_in;
      p1_ff          <= p1_in;
      s_ff           <= s_in;
      area_tri_ff    <= area_tri_in;
      sq_ff          <= sq_in;
      rax_ff         <= rax_in;
      ray_ff         <= ray_in;
      rbx_ff         <= rbx_in;
      rby_ff         <= rby_in;
      ysel_ff        <= ysel_in;
      scaled_ff      <= scaled_in;
      cxm_ff         <= cxm_in;
      cym_ff         <= cym_in;
      res_inertia_ff <= res_inertia_in;
      res_inv_ff     <= res_inv_in;
      res_status_ff  <= res_status_in;
      rsp_inertia_ff <= rsp_inertia_in;
      rsp_inv_ff     <= rsp_inv_in;
      rsp_area_ff    <= rsp_area_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_inertia_out     = rsp_inertia_ff;
   assign rsp_inv_inertia_out = rsp_inv_ff;
   assign rsp_area_out        = rsp_area_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

/* rtl/core/pmi_checker.sv */
// Port-level checker for the polygon inertia unit, with its bind.
`include "polygon_moment_of_inertia_unit_macros.svh"

module pmi_checker
   import pmi_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_inertia_out,
   input logic [63:0] rsp_inv_inertia_out,
   input logic [63:0] rsp_area_out,
   input logic [1:0]  rsp_status
);

   `PMI_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_inertia_out) && $stable(rsp_status), "result transaction changed while stalled")

   `PMI_ASSERT_IMP(a_early_zero, clock, reset, rsp_valid && (rsp_status == ST_FEW || rsp_status == ST_ZERO_AREA), rsp_inertia_out == 64'd0 && rsp_inv_inertia_out == 64'd0, "degenerate polygon with nonzero inertia")

   `PMI_ASSERT_IMP(a_zero_area, clock, reset, rsp_valid && rsp_status == ST_ZERO_AREA, rsp_area_out == 64'd0, "zero area status with nonzero area")

   `PMI_ASSERT_IMP(a_ok_nonzero, clock, reset, rsp_valid && rsp_status == ST_OK, rsp_inertia_out != 64'd0 && rsp_area_out != 64'd0, "ok status with zero inertia or area")

endmodule

bind polygon_moment_of_inertia_unit pmi_checker u_pmi_checker (.*);
